// ===== hdl/rht_pkg.sv =====
// Shared types and constants for the reference-counted handle table.
package rht_pkg;

    localparam int unsigned WORD_W = 32;
    localparam logic [WORD_W-1:0] NO_HANDLE = '1;
    localparam logic [WORD_W-1:0] BASE_RESET = 32'hF800_0000;

    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_DUP     = 3'd1;
    localparam logic [2:0] OP_RELEASE = 3'd2;
    localparam logic [2:0] OP_LOOKUP  = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_INVALID  = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_OVERFLOW = 2'd3;

    typedef enum logic [3:0] {
        S_INIT_CLR,
        S_IDLE,
        S_DECODE,
        S_ERR,
        S_READ,
        S_EXEC,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_CLR,
        S_CLR_DONE
    } t_state;

    typedef struct packed {
        logic load_item;
        logic decode;
        logic rd;
        logic exec;
        logic scan_next;
        logic add_commit;
        logic add_full;
        logic err;
        logic clr_step;
        logic clr_report;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       tag_zero;
        logic       slot_free;
        logic       probe_last;
        logic       clr_last;
        logic       out_free;
    } t_dp_status;

endpackage

// ===== hdl/rht_in_if.sv =====
// Input item channel of the handle table.
interface rht_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [31:0] handle;
    logic [31:0] object_value;

    modport source (output valid, output operation, output handle, output object_value,
                    input ready);
    modport sink (input valid, input operation, input handle, input object_value,
                  output ready);
endinterface

// ===== hdl/rht_out_if.sv =====
// Result item channel of the handle table.
interface rht_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] handle_out;
    logic [31:0] object_out;
    logic [1:0]  status;
    logic        freed;

    modport source (output valid, output handle_out, output object_out, output status,
                    output freed, input ready);
    modport sink (input valid, input handle_out, input object_out, input status,
                  input freed, output ready);
endinterface

// ===== hdl/rht_cfg_if.sv =====
// Configuration write channel carrying the handle base register.
interface rht_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] handle_base;

    modport source (output valid, output handle_base, input ready);
    modport sink (input valid, input handle_base, output ready);
endinterface

// ===== hdl/rht_datapath.sv =====
// Datapath of the handle table: slot memory, handle decode, search pointer and result register.
module rht_datapath #(
    parameter int unsigned TABLE_SLOTS = 64,
    parameter int unsigned COUNT_BITS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rht_pkg::t_dp_cmd    i_cmd,
    output rht_pkg::t_dp_status o_status,
    input  logic [2:0]          i_operation,
    input  logic [31:0]         i_handle,
    input  logic [31:0]         i_object_value,
    rht_cfg_if.sink             i_cfg,
    rht_out_if.source           o_out
);

    localparam int unsigned SLOT_W = $clog2(TABLE_SLOTS);
    localparam int unsigned MEM_W  = COUNT_BITS + rht_pkg::WORD_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    logic [MEM_W-1:0] r_mem [TABLE_SLOTS];
    logic [MEM_W-1:0] r_rd_data;

    logic [2:0]        r_op;
    logic [31:0]       r_handle;
    logic [31:0]       r_tag;
    logic              r_hvalid;
    logic [SLOT_W-1:0] r_addr;
    logic [SLOT_W-1:0] r_probe;
    logic [SLOT_W-1:0] r_search;
    logic [31:0]       r_base;

    logic        r_out_valid;
    logic [31:0] r_hout;
    logic [31:0] r_obj;
    logic [1:0]  r_stat;
    logic        r_freed;

    logic [31:0]           w_off;
    logic                  w_hvalid;
    logic [SLOT_W-1:0]     w_addr_next;
    logic [COUNT_BITS-1:0] w_cnt;
    logic [31:0]           w_slot_tag;
    logic                  w_ok;
    logic                  w_cnt_max;
    logic                  w_cnt_low;
    logic                  w_we;
    logic [MEM_W-1:0]      w_wdata;
    logic                  w_load;
    logic                  w_out_free;
    logic [31:0]           n_hout;
    logic [31:0]           n_obj;
    logic [1:0]            n_stat;
    logic                  n_freed;

    assign i_cfg.ready = 1'b1;

    assign w_off    = r_handle - r_base;
    assign w_hvalid = (r_handle != rht_pkg::NO_HANDLE) && (r_handle >= r_base)
                   && (w_off[31:2] < 30'(TABLE_SLOTS));

    assign w_addr_next = (r_addr == LAST_SLOT) ? '0 : r_addr + SLOT_W'(1);

    assign w_cnt      = r_rd_data[MEM_W-1:rht_pkg::WORD_W];
    assign w_slot_tag = r_rd_data[rht_pkg::WORD_W-1:0];
    assign w_ok       = r_hvalid && (w_slot_tag != '0);
    assign w_cnt_max  = (w_cnt == '1);
    assign w_cnt_low  = (w_cnt[COUNT_BITS-1:1] == '0);

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_load = i_cmd.exec || i_cmd.add_commit || i_cmd.add_full || i_cmd.err
                 || i_cmd.clr_report;

    assign o_status.op         = r_op;
    assign o_status.tag_zero   = (r_tag == '0);
    assign o_status.slot_free  = (w_slot_tag == '0) && (w_cnt == '0);
    assign o_status.probe_last = (r_probe == LAST_SLOT);
    assign o_status.clr_last   = (r_addr == LAST_SLOT);
    assign o_status.out_free   = w_out_free;

    // Memory write data and the next result, selected by the command in force.
    always_comb begin
        w_we    = 1'b0;
        w_wdata = '0;
        n_hout  = rht_pkg::NO_HANDLE;
        n_obj   = '0;
        n_stat  = rht_pkg::STAT_INVALID;
        n_freed = 1'b0;
        if (i_cmd.clr_step) begin
            w_we = 1'b1;
        end
        if (i_cmd.clr_report) begin
            n_stat = rht_pkg::STAT_OK;
        end
        if (i_cmd.add_full) begin
            n_stat = rht_pkg::STAT_FULL;
        end
        if (i_cmd.add_commit) begin
            w_we    = 1'b1;
            w_wdata = {COUNT_BITS'(1), r_tag};
            n_hout  = r_base + 32'({r_addr, 2'b00});
            n_stat  = rht_pkg::STAT_OK;
        end
        if (i_cmd.exec && w_ok) begin
            n_hout = r_handle;
            case (r_op)
                rht_pkg::OP_DUP: begin
                    if (w_cnt_max) begin
                        n_stat = rht_pkg::STAT_OVERFLOW;
                    end else begin
                        n_stat  = rht_pkg::STAT_OK;
                        w_we    = 1'b1;
                        w_wdata = {w_cnt + COUNT_BITS'(1), w_slot_tag};
                    end
                end
                rht_pkg::OP_RELEASE: begin
                    n_stat = rht_pkg::STAT_OK;
                    w_we   = 1'b1;
                    if (w_cnt_low) begin
                        w_wdata = '0;
                        n_freed = 1'b1;
                    end else begin
                        w_wdata = {w_cnt - COUNT_BITS'(1), w_slot_tag};
                    end
                end
                rht_pkg::OP_LOOKUP: begin
                    n_stat = rht_pkg::STAT_OK;
                    n_obj  = w_slot_tag;
                end
                default: begin
                    n_hout = rht_pkg::NO_HANDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_addr] <= w_wdata;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_search    <= '0;
            r_base      <= rht_pkg::BASE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_base <= i_cfg.handle_base;
            end
            if (i_cmd.decode) begin
                case (r_op)
                    rht_pkg::OP_ADD: r_addr <= r_search;
                    rht_pkg::OP_CLEAR: r_addr <= '0;
                    default: r_addr <= w_hvalid ? w_off[SLOT_W+1:2] : '0;
                endcase
            end
            if (i_cmd.scan_next || i_cmd.clr_step) begin
                r_addr <= w_addr_next;
            end
            if (i_cmd.clr_step) begin
                r_search <= '0;
            end
            if (i_cmd.add_commit) begin
                r_search <= w_addr_next;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op     <= i_operation;
            r_handle <= i_handle;
            r_tag    <= i_object_value;
        end
        if (i_cmd.decode) begin
            r_hvalid <= w_hvalid;
            r_probe  <= '0;
        end
        if (i_cmd.scan_next) begin
            r_probe <= r_probe + SLOT_W'(1);
        end
        if (w_load) begin
            r_hout  <= n_hout;
            r_obj   <= n_obj;
            r_stat  <= n_stat;
            r_freed <= n_freed;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.handle_out = r_hout;
    assign o_out.object_out = r_obj;
    assign o_out.status     = r_stat;
    assign o_out.freed      = r_freed;

`ifndef SYNTHESIS
    // A new result is loaded only into an empty or departing result register.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_out_free)
        else $error("result loaded over an untaken result");

    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_addr <= LAST_SLOT))
        else $error("slot write outside the table");

    a_freed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.freed) |-> (o_out.status == rht_pkg::STAT_OK))
        else $error("freed flag on a failed release");

    // After an add the search resumes past the slot just taken.
    a_search_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add_commit |=> (r_search != $past(r_addr)))
        else $error("search pointer did not move past the new slot");
`endif

endmodule

// ===== hdl/rht_ctrl.sv =====
// Controller state machine sequencing decode, slot access, free-slot search and clearing.
module rht_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rht_pkg::t_dp_status i_status,
    output rht_pkg::t_dp_cmd    o_cmd
);

    rht_pkg::t_state r_state;
    rht_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rht_pkg::S_INIT_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            rht_pkg::S_INIT_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = rht_pkg::S_IDLE;
                end
            end
            rht_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = rht_pkg::S_DECODE;
                end
            end
            rht_pkg::S_DECODE: begin
                o_cmd.decode = 1'b1;
                case (i_status.op)
                    rht_pkg::OP_ADD: begin
                        n_state = i_status.tag_zero ? rht_pkg::S_ERR : rht_pkg::S_SCAN_RD;
                    end
                    rht_pkg::OP_DUP,
                    rht_pkg::OP_RELEASE,
                    rht_pkg::OP_LOOKUP: n_state = rht_pkg::S_READ;
                    rht_pkg::OP_CLEAR: n_state = rht_pkg::S_CLR;
                    default: n_state = rht_pkg::S_ERR;
                endcase
            end
            rht_pkg::S_ERR: begin
                if (i_status.out_free) begin
                    o_cmd.err = 1'b1;
                    n_state = rht_pkg::S_IDLE;
                end
            end
            rht_pkg::S_READ: begin
                o_cmd.rd = 1'b1;
                n_state = rht_pkg::S_EXEC;
            end
            rht_pkg::S_EXEC: begin
                if (i_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state = rht_pkg::S_IDLE;
                end
            end
            rht_pkg::S_SCAN_RD: begin
                o_cmd.rd = 1'b1;
                n_state = rht_pkg::S_SCAN_CHK;
            end
            rht_pkg::S_SCAN_CHK: begin
                if (i_status.slot_free) begin
                    if (i_status.out_free) begin
                        o_cmd.add_commit = 1'b1;
                        n_state = rht_pkg::S_IDLE;
                    end
                end else if (i_status.probe_last) begin
                    if (i_status.out_free) begin
                        o_cmd.add_full = 1'b1;
                        n_state = rht_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state = rht_pkg::S_SCAN_RD;
                end
            end
            rht_pkg::S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = rht_pkg::S_CLR_DONE;
                end
            end
            rht_pkg::S_CLR_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.clr_report = 1'b1;
                    n_state = rht_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rht_pkg::S_INIT_CLR;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == rht_pkg::S_DECODE))
        else $error("accepted transaction not decoded next");

    // Memory writes of a clearing sweep never overlap the result of an operation.
    a_clr_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clr_step |-> !(o_cmd.exec || o_cmd.add_commit || o_cmd.load_item))
        else $error("clearing step combined with another slot operation");

    a_scan_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rht_pkg::S_SCAN_CHK) |-> ($past(r_state) == rht_pkg::S_SCAN_RD
            || $past(r_state) == rht_pkg::S_SCAN_CHK))
        else $error("slot check without a preceding slot read");
`endif

endmodule

// ===== hdl/refcounted_handle_table_unit.sv =====
// Top level of the reference-counted handle table.
//
//  channel   modport  direction  carries
//  i_in      sink     in         operation, handle, object_value
//  o_out     source   out        handle_out, object_out, status, freed
//  i_cfg     sink     in         handle_base (always ready)
//
// Duplicate, release and lookup pass from acceptance to result through decode, slot
// read and update; the single-port slot memory sets this sequence.
// Add decodes and then probes from 1 to TABLE_SLOTS slots, with one memory read and
// one check per probed slot. Clear sweeps every slot and then reports its result.
// After reset a clearing pass over every slot runs before the first transaction
// is accepted; configuration writes are taken throughout.
// One item is in work at a time; a result waiting in the output register stalls
// only the next result, not the next acceptance.
module refcounted_handle_table_unit #(
    parameter int unsigned TABLE_SLOTS = 64,
    parameter int unsigned COUNT_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rht_in_if.sink    i_in,
    rht_out_if.source o_out,
    rht_cfg_if.sink   i_cfg
);

    rht_pkg::t_dp_cmd    w_cmd;
    rht_pkg::t_dp_status w_status;
    logic                w_in_ready;

    assign i_in.ready = w_in_ready;

    rht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rht_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_operation    (i_in.operation),
        .i_handle       (i_in.handle),
        .i_object_value (i_in.object_value),
        .i_cfg          (i_cfg),
        .o_out          (o_out)
    );

endmodule
